// File: src/uels_pkg.sv
package uels_pkg;

   localparam int VERTEX_W = 8;

   localparam logic [1:0] OP_INSERT    = 2'd0;
   localparam logic [1:0] OP_LOOKUP    = 2'd1;
   localparam logic [1:0] OP_NEIGHBORS = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SELF_LOOP = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN   = 3'd2;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [5:0]          edge_slot;
      logic [VERTEX_W-1:0] neighbor;
      logic                neighbor_valid;
      logic [6:0]          edge_total;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] lo;
      logic [VERTEX_W-1:0] hi;
   } edge_type;

endpackage

// File: src/undirected_edge_list_store.sv
// Undirected edge table held in a ring of MAX_EDGES cells. Every operation
// (insert, lookup, neighbors) rotates the whole ring once past a single
// comparator at the head, one slot per cycle, whatever the fill level;
// busy is high from the scan through the completion state. Neighbor
// results stream out during the rotation, at most one per cycle; each word
// is held until the next match or the end of the turn and then leaves
// through the output register, with the final one marked by last. Results
// are strobed on rsp_valid for one cycle and cannot be held off. An unused
// opcode is taken and dropped with no result. csr_ready is always high;
// vertex_count should be written only while busy is low.
module undirected_edge_list_store #(
   parameter int MAX_EDGES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  uels_pkg::req_type req_data,
   output logic              rsp_valid,
   output uels_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [8:0]        csr_data
);
   import uels_pkg::*;

   localparam int SLOT_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [8:0]          vcount_ff;
   logic [1:0]          op_ff, op_in;
   logic [VERTEX_W-1:0] a_ff, a_in, lo_ff, lo_in, hi_ff, hi_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   fslot_ff, fslot_in;
   logic                pend_ff, pend_in;
   logic [VERTEX_W-1:0] pnb_ff, pnb_in;
   logic [SLOT_W-1:0]   pslot_ff, pslot_in;
   logic                ins_ff, ins_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                shift;
   edge_type            feed;
   edge_type            head;
   edge_type            ring [MAX_EDGES];

   logic [SLOT_W-1:0]   slot;
   logic                in_table, pair_hit, nb_hit, ins_ok;
   logic [VERTEX_W-1:0] nb;
   logic [VERTEX_W-1:0] req_lo, req_hi;
   logic [CNT_W-1:0]    last_pos;
   logic [SLOT_W+5:0]   pslot_x, fslot_x, cslot_x;
   logic [CNT_W+6:0]    cnt_x, cnt_new_x;

   // ring: cell i takes from cell i+1, the tail takes the feed
   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      if (i == MAX_EDGES - 1) begin : g_tail
         uels_cell u_cell (.clock(clock), .shift(shift), .edge_in(feed),
                           .edge_out(ring[i]));
      end else begin : g_body
         uels_cell u_cell (.clock(clock), .shift(shift), .edge_in(ring[i+1]),
                           .edge_out(ring[i]));
      end
   end

   assign head     = ring[0];
   assign slot     = pos_ff[SLOT_W-1:0];
   assign last_pos = CNT_W'(MAX_EDGES - 1);
   assign in_table = pos_ff < count_ff;
   assign pair_hit = in_table && head.lo == lo_ff && head.hi == hi_ff;
   assign nb_hit   = in_table && (head.lo == a_ff || head.hi == a_ff);
   assign nb       = (head.lo == a_ff) ? head.hi : head.lo;
   assign ins_ok   = op_ff == OP_INSERT && lo_ff != hi_ff &&
                     {1'b0, hi_ff} < vcount_ff && !found_ff;

   assign req_lo = (req_data.vertex_a < req_data.vertex_b) ? req_data.vertex_a
                                                          : req_data.vertex_b;
   assign req_hi = (req_data.vertex_a < req_data.vertex_b) ? req_data.vertex_b
                                                          : req_data.vertex_a;

   // fit internal slot and count widths to the fixed output fields
   assign pslot_x   = {6'b0, pslot_ff};
   assign fslot_x   = {6'b0, fslot_ff};
   assign cslot_x   = {6'b0, count_ff[SLOT_W-1:0]};
   assign cnt_x     = {7'b0, count_ff};
   assign cnt_new_x = {7'b0, count_in};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      found_in     = found_ff;
      fslot_in     = fslot_ff;
      pend_in      = pend_ff;
      pnb_in       = pnb_ff;
      pslot_in     = pslot_ff;
      ins_in       = ins_ff;
      shift        = 1'b0;
      feed         = head;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_data.opcode != OP_NONE) begin
               state_in = S_SCAN;
               pos_in   = '0;
               op_in    = req_data.opcode;
               a_in     = req_data.vertex_a;
               lo_in    = req_lo;
               hi_in    = req_hi;
               found_in = 1'b0;
               pend_in  = 1'b0;
               ins_in   = 1'b0;
            end
         end
         S_SCAN: begin
            shift = 1'b1;
            if (pair_hit && !found_ff) begin
               found_in = 1'b1;
               fslot_in = slot;
            end
            if (op_ff == OP_NEIGHBORS && nb_hit) begin
               // hold one word back so the final one can carry last
               if (pend_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = STATUS_OK;
                  rsp_in.edge_slot      = pslot_x[5:0];
                  rsp_in.neighbor       = pnb_ff;
                  rsp_in.neighbor_valid = 1'b1;
                  rsp_in.edge_total     = cnt_x[6:0];
               end
               pend_in  = 1'b1;
               pnb_in   = nb;
               pslot_in = slot;
            end
            // first free slot passes the head only after every stored edge
            if (ins_ok && pos_ff == count_ff) begin
               feed.lo = lo_ff;
               feed.hi = hi_ff;
               ins_in  = 1'b1;
            end
            if (pos_ff == last_pos) begin
               state_in = S_DONE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_DONE: begin
            state_in          = S_IDLE;
            count_in          = count_ff + CNT_W'(ins_ff);
            rsp_valid_in      = 1'b1;
            rsp_in.edge_total = cnt_new_x[6:0];
            rsp_in.last       = 1'b1;
            if (op_ff == OP_INSERT) begin
               priority if (lo_ff == hi_ff) begin
                  rsp_in.status = STATUS_SELF_LOOP;
               end else if ({1'b0, hi_ff} >= vcount_ff) begin
                  rsp_in.status = STATUS_UNKNOWN;
               end else if (found_ff) begin
                  rsp_in.status    = STATUS_DUPLICATE;
                  rsp_in.edge_slot = fslot_x[5:0];
               end else if (!ins_ff) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status    = STATUS_OK;
                  rsp_in.edge_slot = cslot_x[5:0];
               end
            end else if (op_ff == OP_LOOKUP) begin
               if (found_ff) begin
                  rsp_in.status    = STATUS_OK;
                  rsp_in.edge_slot = fslot_x[5:0];
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end else begin
               rsp_in.status = STATUS_OK;
               if (pend_ff) begin
                  rsp_in.edge_slot      = pslot_x[5:0];
                  rsp_in.neighbor       = pnb_ff;
                  rsp_in.neighbor_valid = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      found_ff <= found_in;
      fslot_ff <= fslot_in;
      pend_ff  <= pend_in;
      pnb_ff   <= pnb_in;
      pslot_ff <= pslot_in;
      ins_ff   <= ins_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond table size");

   a_done_after_full_turn: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> $past(state_ff == S_SCAN && pos_ff == last_pos))
      else $error("scan ended before a full rotation");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_SCAN || state_ff == S_DONE))
      else $error("result word outside an operation");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         ($past(state_ff == S_DONE) && count_ff == $past(count_ff) + 1'b1))
      else $error("edge count changed outside completion");

   a_last_ends_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !busy)
      else $error("final word while still scanning");

endmodule

// File: src/uels_cell.sv
module uels_cell (
   input  logic              clock,
   input  logic              shift,
   input  uels_pkg::edge_type edge_in,
   output uels_pkg::edge_type edge_out
);
   import uels_pkg::*;

   edge_type edge_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         edge_ff <= edge_in;
      end
   end

   assign edge_out = edge_ff;

endmodule
